### src/water_ripple_frame_filter_macros.svh
// assertion macros shared by the ripple filter checker
`ifndef WATER_RIPPLE_FRAME_FILTER_MACROS_SVH
`define WATER_RIPPLE_FRAME_FILTER_MACROS_SVH

// condition and consequence in the same cycle
`define WRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence in the cycle after the condition
`define WRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/wrf_pkg.sv
// shared types and constants of the water ripple frame filter
package wrf_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 512;
   localparam int MAX_HEIGHT_DEFAULT = 512;
   localparam int SIZE_RESET         = 512;
   localparam int SIZE_MIN           = 2;

   localparam int CFG_BITS       = 10;
   localparam int CSR_INDEX_BITS = 1;
   localparam int PIXEL_BITS     = 24;
   localparam int CHAN_BITS      = 8;
   localparam int CHANNELS       = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [PIXEL_BITS-1:0] pixel_rgb;
   } req_word_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] out_rgb;
      logic                  frame_last;
   } rsp_word_type;

   // neighbourhood of one output pixel, handed to the filter arithmetic
   typedef struct packed {
      logic [PIXEL_BITS-1:0] up;
      logic [PIXEL_BITS-1:0] down;
      logic [PIXEL_BITS-1:0] left;
      logic [PIXEL_BITS-1:0] right;
      logic [PIXEL_BITS-1:0] prev;
      logic                  has_up;
      logic                  has_down;
      logic                  has_left;
      logic                  has_right;
   } calc_in_type;

endpackage

### src/water_ripple_frame_filter.sv
// top level of the water ripple frame filter
//
// Pixels of a frame enter in raster order on the req_ channel (req_type pixel),
// and after the frame's last pixel one drain word per column flushes the last
// row. Each result word carries the filtered rgb of one pixel, in raster order,
// with frame_last set on the final pixel of the frame. Pixel words that arrive
// while a drain is pending, and drain words with nothing pending, are taken and
// dropped. Results trail the input by one row.
// A result passes through the stage-1 registers and the output register to rsp_;
// one word is taken per cycle while req_stall is low, set by the single
// read-modify-write of the previous-frame memory and the two-read line window.
// When the receiver stalls, the output register holds its word and one more
// result waits in the stage behind it; req_stall rises only then.
// Reset sets width and height to 512 (clamped to the maximum) and empties the
// pipeline. The previous frame reads as zero until its first full frame is
// written, so reset needs no clearing pass. A csr_ write that changes the
// clamped size restarts the frame the same way.
module water_ripple_frame_filter #(
   parameter int MAX_WIDTH  = wrf_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = wrf_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wrf_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wrf_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_we,
   input  logic [wrf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wrf_pkg::CFG_BITS-1:0]        csr_wdata
);

   localparam int WinDepth   = 2 * MAX_WIDTH + 1;
   localparam int WinBits    = $clog2(WinDepth);
   localparam int StoreDepth = MAX_WIDTH * MAX_HEIGHT;
   localparam int StoreBits  = $clog2(StoreDepth);
   localparam int WBits      = $clog2(MAX_WIDTH + 1);
   localparam int HBits      = $clog2(MAX_HEIGHT + 1);
   localparam int XBits      = $clog2(MAX_WIDTH);
   localparam int YBits      = $clog2(MAX_HEIGHT);
   localparam int PBits      = wrf_pkg::PIXEL_BITS;
   localparam int WidthReset =
      (wrf_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : wrf_pkg::SIZE_RESET;
   localparam int HeightReset =
      (wrf_pkg::SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : wrf_pkg::SIZE_RESET;

   // memories
   logic [PBits-1:0] win_mem   [WinDepth];
   logic [PBits-1:0] store_mem [StoreDepth];

   // configuration
   logic [WBits-1:0] width_ff, width_in, width_clamp;
   logic [HBits-1:0] height_ff, height_in, height_clamp;
   logic             size_clear;

   // frame position
   logic [XBits-1:0]     in_x_ff, in_x_in;
   logic [YBits-1:0]     in_y_ff, in_y_in;
   logic [WinBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [XBits-1:0]     out_x_ff, out_x_in;
   logic [YBits-1:0]     out_y_ff, out_y_in;
   logic [WinBits-1:0]   out_ptr_ff, out_ptr_in;
   logic [StoreBits-1:0] out_addr_ff, out_addr_in;
   logic [WBits-1:0]     pending_ff, pending_in;
   logic                 first_ff, first_in;

   // middle-row taps
   logic [PBits-1:0] prev_tap_ff, prev_tap_in;
   logic [PBits-1:0] cur_tap_ff, cur_tap_in;
   logic [PBits-1:0] next_val;
   logic             fwd_ff;
   logic [PBits-1:0] fwd_data_ff;
   logic [PBits-1:0] nxt_q_ff;

   // stage 1 and output register
   logic             s1_valid_ff, s1_valid_in;
   logic [PBits-1:0] up_q_ff, prev_q_ff;
   logic [PBits-1:0] s1_down_ff, s1_left_ff, s1_right_ff;
   logic             s1_has_up_ff, s1_has_down_ff, s1_has_left_ff, s1_has_right_ff;
   logic             s1_last_ff, s1_first_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   wrf_pkg::rsp_word_type rsp_word_ff;

   wrf_pkg::calc_in_type   calc_in;
   logic [PBits-1:0]       calc_rgb;

   // handshake and item decode
   logic accept, is_drain, pend_nz, pix_go, drain_go, out_go;
   logic in_row0, in_last_x, in_last_y, out_last_x, out_last_y, out_last;
   logic out_free, s1_adv;
   logic prime_cur, prime_next, rd_b_en, fwd_in;

   logic [WinBits:0]   ptr_ext, w_ext, p2_ext;
   logic [WinBits-1:0] addr_a, addr_b;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   assign accept   = req_valid && !req_stall;
   assign is_drain = (req_word.req_type == wrf_pkg::REQ_DRAIN);
   assign pend_nz  = (pending_ff != '0);
   assign pix_go   = accept && !is_drain && !pend_nz;
   assign drain_go = accept && is_drain && pend_nz;
   assign in_row0  = (in_y_ff == '0);
   assign out_go   = drain_go || (pix_go && !in_row0);

   assign in_last_x  = (WBits'(in_x_ff) == width_ff - 1'b1);
   assign in_last_y  = (HBits'(in_y_ff) == height_ff - 1'b1);
   assign out_last_x = (WBits'(out_x_ff) == width_ff - 1'b1);
   assign out_last_y = (HBits'(out_y_ff) == height_ff - 1'b1);
   assign out_last   = out_last_x && out_last_y;

   // first two pixels of a frame seed the middle-row taps
   assign prime_cur  = pix_go && in_row0 && (in_x_ff == XBits'(0));
   assign prime_next = pix_go && in_row0 && (in_x_ff == XBits'(1));

   // window addresses: row above and two ahead in the middle row
   assign ptr_ext = {1'b0, out_ptr_ff};
   assign w_ext   = (WinBits+1)'(width_ff);
   assign p2_ext  = ptr_ext + (WinBits+1)'(2);
   assign addr_a  = (ptr_ext >= w_ext) ? WinBits'(ptr_ext - w_ext)
                  : WinBits'(ptr_ext + (WinBits+1)'(WinDepth) - w_ext);
   assign addr_b  = !out_go ? wr_ptr_ff
                  : (p2_ext >= (WinBits+1)'(WinDepth)) ? WinBits'(p2_ext - (WinBits+1)'(WinDepth))
                  : WinBits'(p2_ext);
   assign rd_b_en = out_go || prime_next;
   // the word being written this cycle bypasses the window read
   assign fwd_in  = pix_go && (addr_b == wr_ptr_ff);
   assign next_val = fwd_ff ? fwd_data_ff : nxt_q_ff;

   // size registers saturate to 2..max
   always_comb begin
      if (int'(csr_wdata) < wrf_pkg::SIZE_MIN) begin
         width_clamp = WBits'(wrf_pkg::SIZE_MIN);
      end else if (int'(csr_wdata) > MAX_WIDTH) begin
         width_clamp = WBits'(MAX_WIDTH);
      end else begin
         width_clamp = WBits'(csr_wdata);
      end
      if (int'(csr_wdata) < wrf_pkg::SIZE_MIN) begin
         height_clamp = HBits'(wrf_pkg::SIZE_MIN);
      end else if (int'(csr_wdata) > MAX_HEIGHT) begin
         height_clamp = HBits'(MAX_HEIGHT);
      end else begin
         height_clamp = HBits'(csr_wdata);
      end
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      size_clear = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            wrf_pkg::REG_FRAME_WIDTH: begin
               if (width_clamp != width_ff) begin
                  width_in   = width_clamp;
                  size_clear = 1'b1;
               end
            end
            wrf_pkg::REG_FRAME_HEIGHT: begin
               if (height_clamp != height_ff) begin
                  height_in  = height_clamp;
                  size_clear = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      in_x_in     = in_x_ff;
      in_y_in     = in_y_ff;
      wr_ptr_in   = wr_ptr_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_ptr_in  = out_ptr_ff;
      out_addr_in = out_addr_ff;
      pending_in  = pending_ff;
      first_in    = first_ff;
      prev_tap_in = prev_tap_ff;
      cur_tap_in  = cur_tap_ff;

      if (pix_go) begin
         wr_ptr_in = (wr_ptr_ff == WinBits'(WinDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (in_last_x) begin
            in_x_in = '0;
            in_y_in = in_y_ff + 1'b1;
         end else begin
            in_x_in = in_x_ff + 1'b1;
         end
         if (in_last_x && in_last_y) begin
            in_x_in    = '0;
            in_y_in    = '0;
            wr_ptr_in  = '0;
            pending_in = width_ff;
         end
      end

      if (prime_cur) begin
         cur_tap_in = req_word.pixel_rgb;
      end

      if (out_go) begin
         prev_tap_in = cur_tap_ff;
         cur_tap_in  = next_val;
         out_ptr_in  = (out_ptr_ff == WinBits'(WinDepth - 1)) ? '0 : out_ptr_ff + 1'b1;
         out_addr_in = out_addr_ff + 1'b1;
         if (out_last_x) begin
            out_x_in = '0;
            out_y_in = out_y_ff + 1'b1;
         end else begin
            out_x_in = out_x_ff + 1'b1;
         end
         if (out_last) begin
            first_in = 1'b0;
         end
      end

      if (drain_go) begin
         pending_in = pending_ff - 1'b1;
         if (pending_ff == WBits'(1)) begin
            out_x_in    = '0;
            out_y_in    = '0;
            out_ptr_in  = '0;
            out_addr_in = '0;
         end
      end

      if (size_clear) begin
         in_x_in     = '0;
         in_y_in     = '0;
         wr_ptr_in   = '0;
         out_x_in    = '0;
         out_y_in    = '0;
         out_ptr_in  = '0;
         out_addr_in = '0;
         pending_in  = '0;
         first_in    = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (out_go) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WBits'(WidthReset);
         height_ff    <= HBits'(HeightReset);
         in_x_ff      <= '0;
         in_y_ff      <= '0;
         wr_ptr_ff    <= '0;
         out_x_ff     <= '0;
         out_y_ff     <= '0;
         out_ptr_ff   <= '0;
         out_addr_ff  <= '0;
         pending_ff   <= '0;
         first_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_x_ff      <= in_x_in;
         in_y_ff      <= in_y_in;
         wr_ptr_ff    <= wr_ptr_in;
         out_x_ff     <= out_x_in;
         out_y_ff     <= out_y_in;
         out_ptr_ff   <= out_ptr_in;
         out_addr_ff  <= out_addr_in;
         pending_ff   <= pending_in;
         first_ff     <= first_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_tap_ff <= prev_tap_in;
      cur_tap_ff  <= cur_tap_in;
      if (rd_b_en) begin
         fwd_ff      <= fwd_in;
         fwd_data_ff <= req_word.pixel_rgb;
      end
      if (out_go) begin
         s1_down_ff      <= req_word.pixel_rgb;
         s1_left_ff      <= prev_tap_ff;
         s1_right_ff     <= next_val;
         s1_has_up_ff    <= (out_y_ff != '0);
         s1_has_down_ff  <= !out_last_y;
         s1_has_left_ff  <= (out_x_ff != '0);
         s1_has_right_ff <= !out_last_x;
         s1_last_ff      <= out_last;
         s1_first_ff     <= first_ff;
      end
      if (s1_adv) begin
         rsp_word_ff.out_rgb    <= calc_rgb;
         rsp_word_ff.frame_last <= s1_last_ff;
      end
   end

   // line window: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (pix_go) begin
         win_mem[wr_ptr_ff] <= req_word.pixel_rgb;
      end
      if (out_go) begin
         up_q_ff <= win_mem[addr_a];
      end
      if (rd_b_en) begin
         nxt_q_ff <= win_mem[addr_b];
      end
   end

   // previous frame: read old value, write current pixel at the same address
   always_ff @(posedge clock) begin
      if (out_go) begin
         prev_q_ff              <= store_mem[out_addr_ff];
         store_mem[out_addr_ff] <= cur_tap_ff;
      end
   end

   always_comb begin
      calc_in.up        = up_q_ff;
      calc_in.down      = s1_down_ff;
      calc_in.left      = s1_left_ff;
      calc_in.right     = s1_right_ff;
      calc_in.prev      = s1_first_ff ? '0 : prev_q_ff;
      calc_in.has_up    = s1_has_up_ff;
      calc_in.has_down  = s1_has_down_ff;
      calc_in.has_left  = s1_has_left_ff;
      calc_in.has_right = s1_has_right_ff;
   end

   wrf_ripple_calc u_calc (
      .calc_in (calc_in),
      .out_rgb (calc_rgb)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### src/wrf_ripple_calc.sv
// per-channel ripple arithmetic: neighbour sum, halving, previous-frame subtract, clamp
module wrf_ripple_calc (
   input  wrf_pkg::calc_in_type                calc_in,
   output logic [wrf_pkg::PIXEL_BITS-1:0]      out_rgb
);

   localparam int SumBits = wrf_pkg::CHAN_BITS + 2;

   logic [SumBits-1:0] sum   [wrf_pkg::CHANNELS];
   logic [SumBits-1:0] term  [wrf_pkg::CHANNELS];
   logic [SumBits:0]   diff  [wrf_pkg::CHANNELS];
   logic               corner;

   // corners have two neighbours and skip the halving
   assign corner = (!calc_in.has_up || !calc_in.has_down) &&
                   (!calc_in.has_left || !calc_in.has_right);

   always_comb begin
      for (int c = 0; c < wrf_pkg::CHANNELS; c++) begin
         sum[c] = (calc_in.has_up    ? SumBits'(calc_in.up[c*8 +: 8])    : '0) +
                  (calc_in.has_down  ? SumBits'(calc_in.down[c*8 +: 8])  : '0) +
                  (calc_in.has_left  ? SumBits'(calc_in.left[c*8 +: 8])  : '0) +
                  (calc_in.has_right ? SumBits'(calc_in.right[c*8 +: 8]) : '0);
         term[c] = corner ? sum[c] : (sum[c] >> 1);
         diff[c] = {1'b0, term[c]} - (SumBits+1)'(calc_in.prev[c*8 +: 8]);
         if (diff[c][SumBits]) begin
            out_rgb[c*8 +: 8] = '0;
         end else if (diff[c][SumBits-1:wrf_pkg::CHAN_BITS] != '0) begin
            out_rgb[c*8 +: 8] = '1;
         end else begin
            out_rgb[c*8 +: 8] = diff[c][wrf_pkg::CHAN_BITS-1:0];
         end
      end
   end

endmodule

### src/wrf_checker.sv
// port-level checks of the ripple filter, bound to the top level
`include "water_ripple_frame_filter_macros.svh"

module wrf_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input wrf_pkg::rsp_word_type rsp_word
);

   `WRF_ASSERT_NEXT(rsp_held_a, rsp_valid && rsp_stall, rsp_valid, "rsp word dropped while stalled")
   `WRF_ASSERT_NEXT(rsp_stable_a, rsp_valid && rsp_stall, $stable(rsp_word), "stalled rsp word changed")
   // input backs up only when the output side is full and stalled
   `WRF_ASSERT_NOW(stall_cause_a, req_stall, rsp_valid && rsp_stall, "req stalled without rsp stall")
   // a fresh result comes from a word taken before it
   `WRF_ASSERT_NOW(rsp_source_a, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "rsp without req")

endmodule

bind water_ripple_frame_filter wrf_checker u_wrf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

### verif/tb_top.sv
// testbench for the water ripple frame filter: random raster frames checked against a local model
module tb_top;
   import wrf_pkg::*;

   localparam int MAX_W       = MAX_WIDTH_DEFAULT;
   localparam int MAX_H       = MAX_HEIGHT_DEFAULT;
   localparam int WIN_DEPTH   = 2 * MAX_W + 1;
   localparam int STORE_DEPTH = MAX_W * MAX_H;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOWN_LIMIT = 10;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_word_type              req_word  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   water_ripple_frame_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // local copy of the filter state
   int unsigned     cfg_w = SIZE_RESET;
   int unsigned     cfg_h = SIZE_RESET;
   bit [23:0]       ripple_win [WIN_DEPTH];
   bit [23:0]       prev_frame [STORE_DEPTH];
   int unsigned     in_idx = 0;
   int unsigned     out_idx = 0;
   int unsigned     drain_left = 0;

   req_word_type    req_backlog [$];
   rsp_word_type    expected_pixels [$];
   logic            req_took = 1'b0;
   int              send_idle_pct = 31;
   int              recv_stall_pct = 76;
   int              hold_left = 0;
   bit              long_hold_req = 1'b0;
   int unsigned     cycle_count = 0;
   int unsigned     mismatches = 0;
   int unsigned     random_items = 0;

   function automatic int unsigned clamp_size(logic [CFG_BITS-1:0] raw, int unsigned hi);
      if (raw < SIZE_MIN)
         return SIZE_MIN;
      if (raw > hi)
         return hi;
      return raw;
   endfunction

   // only the part of the store the old size could touch needs clearing
   function automatic void restart_frame();
      int unsigned i;
      for (i = 0; i < cfg_w * cfg_h; i++)
         prev_frame[i] = '0;
      foreach (ripple_win[j])
         ripple_win[j] = '0;
      in_idx = 0;
      out_idx = 0;
      drain_left = 0;
   endfunction

   function automatic rsp_word_type ripple_pixel(int unsigned o);
      int unsigned  row, col, n, c, k;
      bit [23:0]    nb [4];
      bit [23:0]    old_px;
      int           sum, v;
      rsp_word_type r;
      row = o / cfg_w;
      col = o % cfg_w;
      n = 0;
      if (row > 0) begin
         nb[n] = ripple_win[(o - cfg_w) % WIN_DEPTH];
         n++;
      end
      if (row + 1 < cfg_h) begin
         nb[n] = ripple_win[(o + cfg_w) % WIN_DEPTH];
         n++;
      end
      if (col > 0) begin
         nb[n] = ripple_win[(o - 1) % WIN_DEPTH];
         n++;
      end
      if (col + 1 < cfg_w) begin
         nb[n] = ripple_win[(o + 1) % WIN_DEPTH];
         n++;
      end
      old_px = prev_frame[o];
      r = '0;
      for (c = 0; c < CHANNELS; c++) begin
         sum = 0;
         for (k = 0; k < n; k++)
            sum += int'(nb[k][CHAN_BITS*c +: CHAN_BITS]);
         // corners keep the full two-neighbour sum
         if (n > 2)
            sum = sum / 2;
         v = sum - int'(old_px[CHAN_BITS*c +: CHAN_BITS]);
         if (v < 0)
            v = 0;
         else if (v > 255)
            v = 255;
         r.out_rgb[CHAN_BITS*c +: CHAN_BITS] = v[7:0];
      end
      prev_frame[o] = ripple_win[o % WIN_DEPTH];
      r.frame_last = (o + 1 == cfg_w * cfg_h);
      return r;
   endfunction

   function automatic void ripple_accept(req_word_type w);
      if (w.req_type == REQ_DRAIN) begin
         if (drain_left == 0)
            return;
         expected_pixels.push_back(ripple_pixel(out_idx));
         out_idx++;
         drain_left--;
         if (drain_left == 0)
            out_idx = 0;
         return;
      end
      // pixels are dropped while the last row drains
      if (drain_left != 0)
         return;
      ripple_win[in_idx % WIN_DEPTH] = w.pixel_rgb;
      if (in_idx >= cfg_w) begin
         expected_pixels.push_back(ripple_pixel(out_idx));
         out_idx++;
      end
      in_idx++;
      if (in_idx >= cfg_w * cfg_h) begin
         in_idx = 0;
         drain_left = cfg_w;
      end
   endfunction

   task automatic report_mismatch(string what, rsp_word_type want, rsp_word_type got);
      mismatches++;
      if (mismatches <= SHOWN_LIMIT)
         $display("%s: expected rgb %06h last %0b, got rgb %06h last %0b",
                  what, want.out_rgb, want.frame_last, got.out_rgb, got.frame_last);
   endtask

   // result checking and input prediction
   always @(posedge clock) begin
      rsp_word_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         if (!reset) begin
            if (rsp_valid && !rsp_stall) begin
               if (expected_pixels.size() == 0) begin
                  report_mismatch("unexpected word", '0, rsp_word);
               end else begin
                  want = expected_pixels.pop_front();
                  if (want.out_rgb !== rsp_word.out_rgb ||
                      want.frame_last !== rsp_word.frame_last)
                     report_mismatch("wrong word", want, rsp_word);
               end
            end
            if (req_valid && !req_stall)
               ripple_accept(req_word);
         end
         req_took <= req_valid && !req_stall && !reset;
      end
   end

   // sender and receiver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_word  <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
   end

   // long receiver hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (long_hold_req) begin
         hold_left <= 400;
         long_hold_req = 1'b0;
      end
   end

   task automatic write_size(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] raw);
      int unsigned v;
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= raw;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FRAME_WIDTH) begin
         v = clamp_size(raw, MAX_W);
         if (v != cfg_w) begin
            restart_frame();
            cfg_w = v;
         end
      end else begin
         v = clamp_size(raw, MAX_H);
         if (v != cfg_h) begin
            restart_frame();
            cfg_h = v;
         end
      end
   endtask

   task automatic wait_quiet();
      do
         @(posedge clock);
      while (req_backlog.size() != 0 || req_valid || expected_pixels.size() != 0);
      // a trailing word may cause no result, give the pipeline time to settle
      repeat (8) @(posedge clock);
   endtask

   task automatic push_word(logic kind, logic [PIXEL_BITS-1:0] rgb);
      req_word_type w;
      w.req_type  = kind;
      w.pixel_rgb = rgb;
      req_backlog.push_back(w);
   endtask

   function automatic logic [PIXEL_BITS-1:0] random_rgb();
      logic [PIXEL_BITS-1:0] v;
      int                    c;
      v = $urandom;
      if ($urandom_range(3) == 0) begin
         for (c = 0; c < CHANNELS; c++) begin
            case ($urandom_range(2))
               0: begin
                  v[CHAN_BITS*c +: CHAN_BITS] = 8'h00;
               end
               1: begin
                  v[CHAN_BITS*c +: CHAN_BITS] = 8'hff;
               end
               default: ;
            endcase
         end
      end
      return v;
   endfunction

   task automatic push_pixels(int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         push_word(REQ_PIXEL, random_rgb());
         random_items++;
      end
   endtask

   // whole frames from the current position, last one possibly cut short,
   // with stray drains and pixels mixed in where the block drops them
   task automatic queue_frames(int unsigned frames, bit cut);
      int unsigned total, start, stop, f, i;
      total = cfg_w * cfg_h;
      for (i = 0; i < drain_left; i++)
         push_word(REQ_DRAIN, random_rgb());
      random_items += drain_left;
      start = in_idx;
      for (f = 0; f < frames; f++) begin
         stop = total;
         if (cut && f == frames - 1)
            stop = $urandom_range(total - 1, start);
         for (i = start; i < stop; i++) begin
            if ($urandom_range(99) < 3)
               push_word(REQ_DRAIN, random_rgb());
            push_word(REQ_PIXEL, random_rgb());
            random_items++;
         end
         if (stop == total) begin
            for (i = 0; i < cfg_w; i++) begin
               if ($urandom_range(99) < 3)
                  push_word(REQ_PIXEL, random_rgb());
               push_word(REQ_DRAIN, random_rgb());
               random_items++;
            end
         end
         start = 0;
      end
   endtask

   task automatic pick_idling();
      if (random_items < 620) begin
         send_idle_pct  = 31;
         recv_stall_pct = 76;
      end else if (random_items < 1240) begin
         send_idle_pct  = 76;
         recv_stall_pct = 31;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
   endtask

   initial begin
      logic [PIXEL_BITS-1:0] grid [9];
      int unsigned           i, wv, hv;
      bit                    hold_done;
      hold_done = 1'b0;
      grid = '{24'hffffff, 24'h000000, 24'hffffff, 24'h00ff00, 24'hffffff,
               24'hff0000, 24'h0000ff, 24'h7f7f7f, 24'hffffff};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 2x2 frames from below-minimum writes: corners only
      write_size(REG_FRAME_WIDTH, 10'd0);
      write_size(REG_FRAME_HEIGHT, 10'd1);
      push_word(REQ_DRAIN, 24'hffffff);
      push_word(REQ_PIXEL, 24'h000000);
      push_word(REQ_PIXEL, 24'hffffff);
      push_word(REQ_PIXEL, 24'hffffff);
      push_word(REQ_PIXEL, 24'h000000);
      push_word(REQ_PIXEL, 24'h123456);
      push_word(REQ_DRAIN, 24'h000000);
      push_word(REQ_DRAIN, 24'h000000);
      push_word(REQ_DRAIN, 24'h000000);
      // second frame subtracts the first
      push_word(REQ_PIXEL, 24'h00ff00);
      push_word(REQ_PIXEL, 24'h0000ff);
      push_word(REQ_PIXEL, 24'hff0000);
      push_word(REQ_PIXEL, 24'hffffff);
      push_word(REQ_DRAIN, 24'h000000);
      push_word(REQ_DRAIN, 24'h000000);
      wait_quiet();

      // 3x3: corners, edges and one interior pixel
      write_size(REG_FRAME_WIDTH, 10'd3);
      write_size(REG_FRAME_HEIGHT, 10'd3);
      for (i = 0; i < 9; i++)
         push_word(REQ_PIXEL, grid[i]);
      for (i = 0; i < 3; i++)
         push_word(REQ_DRAIN, 24'h000000);
      wait_quiet();
      write_size(REG_FRAME_WIDTH, 10'd3);

      // widest and tallest frames, only partly sent
      write_size(REG_FRAME_WIDTH, 10'd1023);
      write_size(REG_FRAME_HEIGHT, 10'd2);
      push_pixels(560);
      wait_quiet();
      write_size(REG_FRAME_WIDTH, 10'd2);
      write_size(REG_FRAME_HEIGHT, 10'd512);
      push_pixels(120);
      wait_quiet();

      while (random_items < 1850) begin
         pick_idling();
         if (send_idle_pct == 0 && !hold_done) begin
            // receiver holds off while four frames are offered
            hold_done = 1'b1;
            write_size(REG_FRAME_WIDTH, 10'd4);
            write_size(REG_FRAME_HEIGHT, 10'd3);
            long_hold_req = 1'b1;
            queue_frames(4, 1'b0);
         end else begin
            if ($urandom_range(7) == 0) begin
               // same size again, the frame in progress carries on
               write_size(REG_FRAME_WIDTH, cfg_w);
            end else begin
               wv = $urandom_range(9, 2);
               hv = $urandom_range(6, 2);
               if (wv == 2 && $urandom_range(1) == 1)
                  wv = $urandom_range(1);
               if (hv == 2 && $urandom_range(1) == 1)
                  hv = $urandom_range(1);
               write_size(REG_FRAME_WIDTH, wv);
               write_size(REG_FRAME_HEIGHT, hv);
            end
            queue_frames($urandom_range(3, 1), $urandom_range(3) == 0);
         end
         wait_quiet();
      end

      repeat (20) @(posedge clock);
      while (expected_pixels.size() != 0)
         report_mismatch("missing word", expected_pixels.pop_front(), '0);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/wrf_pkg.sv
src/wrf_ripple_calc.sv
src/water_ripple_frame_filter.sv
src/wrf_checker.sv
verif/tb_top.sv
